[rtl/core/sget_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sget_pkg
// Shared types, sizes and codes of the spatial grid entity table.
// ----------------------------------------------------------------------------
package sget_pkg;

    // table sizes
    localparam int NUM_CELLS    = 4096;
    localparam int BUCKET_DEPTH = 16;
    localparam int NUM_ENTITIES = 1024;

    // derived sizes
    localparam int CELL_W   = $clog2(NUM_CELLS);
    localparam int IDX_W    = (BUCKET_DEPTH > 1) ? $clog2(BUCKET_DEPTH) : 1;
    localparam int CNT_W    = $clog2(BUCKET_DEPTH + 1);
    localparam int ENT_AW   = $clog2(NUM_CELLS * BUCKET_DEPTH);
    localparam int HOME_AW  = $clog2(NUM_ENTITIES);
    localparam int CLR_N    = (NUM_CELLS > NUM_ENTITIES) ? NUM_CELLS : NUM_ENTITIES;
    localparam int CLR_W    = $clog2(CLR_N);

    // field widths
    localparam int ID_W     = 10;
    localparam int POS_W    = 14;
    localparam int Z_W      = 8;
    localparam int QC_W     = 12;
    localparam int CS_W     = 7;
    localparam int DIM_W    = 13;
    localparam int DIV_CNT_W = $clog2(POS_W + 1);
    localparam int M1_W     = POS_W + DIM_W;
    localparam int M2_W     = DIM_W + DIM_W;
    localparam int M3_W     = Z_W + M2_W;
    localparam int SUM_W    = M3_W + 1;

    // configuration port
    localparam int ADDR_W   = 4;
    localparam logic [1:0] REG_CELL_SIZE = 2'd0;
    localparam logic [1:0] REG_CELLS_X   = 2'd1;
    localparam logic [1:0] REG_CELLS_Y   = 2'd2;

    // modes
    localparam logic [1:0] MODE_INSERT = 2'd0;
    localparam logic [1:0] MODE_REMOVE = 2'd1;
    localparam logic [1:0] MODE_MOVE   = 2'd2;
    localparam logic [1:0] MODE_QUERY  = 2'd3;

    // status codes
    localparam logic [2:0] ST_OK        = 3'd0;
    localparam logic [2:0] ST_NOT_FOUND = 3'd1;
    localparam logic [2:0] ST_FULL      = 3'd2;
    localparam logic [2:0] ST_EMPTY     = 3'd3;
    localparam logic [2:0] ST_OUT       = 3'd4;

    typedef struct packed {
        logic [1:0]       mode;
        logic [ID_W-1:0]  entity_id;
        logic [POS_W-1:0] pos_x;
        logic [POS_W-1:0] pos_y;
        logic [Z_W-1:0]   pos_z;
        logic [POS_W-1:0] old_x;
        logic [POS_W-1:0] old_y;
        logic [Z_W-1:0]   old_z;
        logic [QC_W-1:0]  query_cell;
    } item_t;

    typedef struct packed {
        logic [ID_W-1:0] member_id;
        logic [2:0]      status;
        logic            last;
    } result_t;

    typedef struct packed {
        logic [CS_W-1:0]  cell_size;
        logic [DIM_W-1:0] cells_x;
        logic [DIM_W-1:0] cells_y;
    } cfg_t;

    typedef enum logic [2:0] {
        WC_HOLD,
        WC_QC,
        WC_NEW,
        WC_OLD,
        WC_HOME
    } wc_src_t;

    typedef enum logic [1:0] {
        CNT_NONE,
        CNT_INC,
        CNT_DEC
    } cnt_op_t;

    typedef enum logic [1:0] {
        HOME_NONE,
        HOME_SET,
        HOME_CLR
    } home_op_t;

    typedef struct packed {
        logic       load;
        logic       clr_step;
        logic       div_go;
        logic       div_old;
        logic       mul1;
        logic       mul2;
        logic       sum;
        wc_src_t    wc_src;
        logic       n_load;
        logic       i_clr;
        logic       i_inc;
        logic       rd_tail;
        logic       ent_append;
        logic       ent_swap;
        cnt_op_t    cnt_op;
        home_op_t   home_op;
        logic       emit;
        logic [2:0] emit_status;
        logic       emit_member;
        logic       emit_last;
    } dp_cmd_t;

    typedef struct packed {
        logic       clr_done;
        logic       div_done;
        logic       new_ok;
        logic       old_ok;
        logic       same_cell;
        logic       cnt_zero;
        logic       cnt_full;
        logic       home_valid;
        logic       ent_match;
        logic       i_last;
        logic       id_bad;
        logic       qc_bad;
        logic [1:0] mode;
    } dp_sts_t;

endpackage

[rtl/core/sget_div.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sget_div
// Restoring divider of a position by the cell size, one quotient bit a cycle.
// ----------------------------------------------------------------------------
module sget_div
    import sget_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             go,
    input  logic [POS_W-1:0] dividend,
    input  logic [CS_W-1:0]  divisor,
    output logic [POS_W-1:0] quotient,
    output logic             busy
);

    logic [CS_W-1:0]      rem_reg;
    logic [POS_W-1:0]     quo_reg;
    logic [CS_W-1:0]      dvs_reg;
    logic [DIV_CNT_W-1:0] cnt_reg;
    logic                 busy_reg;
    logic [CS_W:0]        rem_sh;
    logic                 ge;

    assign rem_sh = {rem_reg, quo_reg[POS_W-1]};
    assign ge     = rem_sh >= {1'b0, dvs_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else if (go)
        begin
            busy_reg <= 1'b1;
            cnt_reg  <= DIV_CNT_W'(POS_W);
        end
        else if (busy_reg)
        begin
            cnt_reg  <= cnt_reg - 1'b1;
            busy_reg <= cnt_reg != DIV_CNT_W'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (go)
        begin
            rem_reg <= '0;
            quo_reg <= dividend;
            dvs_reg <= divisor;
        end
        else if (busy_reg)
        begin
            rem_reg <= ge ? CS_W'(rem_sh - {1'b0, dvs_reg}) : CS_W'(rem_sh);
            quo_reg <= {quo_reg[POS_W-2:0], ge};
        end
    end

    assign quotient = quo_reg;
    assign busy     = busy_reg;

endmodule

[rtl/core/sget_dp.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sget_dp
// Datapath: cell index arithmetic, bucket, count and home memories, result.
// ----------------------------------------------------------------------------
module sget_dp
    import sget_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  cfg_t    cfg,
    input  item_t   item,
    input  dp_cmd_t cmd,
    output dp_sts_t sts,
    output result_t result,
    output logic    strobe
);

    item_t                item_reg;
    logic [CLR_W-1:0]     clr_reg;
    logic                 strobe_reg;
    result_t              result_reg;

    logic                 sel_old_reg;
    logic [M1_W-1:0]      m1_reg;
    logic [M2_W-1:0]      m2_reg;
    logic [M3_W-1:0]      m3_reg;
    logic                 inrange_reg;
    logic [CELL_W-1:0]    new_cell_reg;
    logic [CELL_W-1:0]    old_cell_reg;
    logic                 new_ok_reg;
    logic                 old_ok_reg;

    logic [CELL_W-1:0]    wc_reg;
    logic [CELL_W-1:0]    wc_next;
    logic [CNT_W-1:0]     n_reg;
    logic [IDX_W-1:0]     i_reg;

    logic [CNT_W-1:0]     cnt_mem [NUM_CELLS];
    logic [ID_W-1:0]      ent_mem [NUM_CELLS*BUCKET_DEPTH];
    logic [CELL_W:0]      home_mem [NUM_ENTITIES];
    logic [CNT_W-1:0]     cnt_q;
    logic [ID_W-1:0]      ent_q;
    logic [CELL_W:0]      home_q;

    logic [CS_W-1:0]      cs_eff;
    logic [POS_W-1:0]     div_x;
    logic [POS_W-1:0]     div_y;
    logic [POS_W-1:0]     qx;
    logic [POS_W-1:0]     qy;
    logic                 busy_x;
    logic                 busy_y;
    logic [Z_W-1:0]       zsel;
    logic [SUM_W-1:0]     idx;

    logic [31:0]          id_ext;
    logic [31:0]          qc_ext;
    logic [31:0]          clr_ext;
    logic                 clr_cells;
    logic                 clr_homes;

    logic                 cnt_we;
    logic [CELL_W-1:0]    cnt_waddr;
    logic [CNT_W-1:0]     cnt_wdata;
    logic                 home_we;
    logic [HOME_AW-1:0]   home_waddr;
    logic [CELL_W:0]      home_wdata;
    logic [HOME_AW-1:0]   home_raddr;
    logic [IDX_W-1:0]     rd_idx;
    logic [IDX_W-1:0]     wr_idx;
    logic [ENT_AW-1:0]    ent_raddr;
    logic [ENT_AW-1:0]    ent_waddr;
    logic [ID_W-1:0]      ent_wdata;
    logic                 ent_we;

    assign cs_eff = (cfg.cell_size == '0) ? CS_W'(1) : cfg.cell_size;
    assign div_x  = cmd.div_old ? item_reg.old_x : item_reg.pos_x;
    assign div_y  = cmd.div_old ? item_reg.old_y : item_reg.pos_y;
    assign zsel   = sel_old_reg ? item_reg.old_z : item_reg.pos_z;

    sget_div u_div_x (
        .clk      (clk),
        .rst_n    (rst_n),
        .go       (cmd.div_go),
        .dividend (div_x),
        .divisor  (cs_eff),
        .quotient (qx),
        .busy     (busy_x)
    );

    sget_div u_div_y (
        .clk      (clk),
        .rst_n    (rst_n),
        .go       (cmd.div_go),
        .dividend (div_y),
        .divisor  (cs_eff),
        .quotient (qy),
        .busy     (busy_y)
    );

    assign idx = SUM_W'(qx) + SUM_W'(m1_reg) + SUM_W'(m3_reg);

    assign id_ext  = 32'(item_reg.entity_id);
    assign qc_ext  = 32'(item_reg.query_cell);
    assign clr_ext = 32'(clr_reg);
    assign clr_cells = clr_ext < 32'(NUM_CELLS);
    assign clr_homes = clr_ext < 32'(NUM_ENTITIES);

    always_comb
    begin
        case (cmd.wc_src)
            WC_QC:   wc_next = qc_ext[CELL_W-1:0];
            WC_NEW:  wc_next = new_cell_reg;
            WC_OLD:  wc_next = old_cell_reg;
            WC_HOME: wc_next = home_q[CELL_W-1:0];
            default: wc_next = wc_reg;
        endcase
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_reg    <= '0;
            strobe_reg <= 1'b0;
        end
        else
        begin
            if (cmd.clr_step)
            begin
                clr_reg <= clr_reg + 1'b1;
            end
            strobe_reg <= cmd.emit;
        end
    end

    // working registers
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            item_reg <= item;
        end
        if (cmd.div_go)
        begin
            sel_old_reg <= cmd.div_old;
        end
        if (cmd.mul1)
        begin
            m1_reg      <= M1_W'(qy) * M1_W'(cfg.cells_x);
            m2_reg      <= M2_W'(cfg.cells_x) * M2_W'(cfg.cells_y);
            inrange_reg <= (qx < POS_W'(cfg.cells_x)) && (qy < POS_W'(cfg.cells_y));
        end
        if (cmd.mul2)
        begin
            m3_reg <= M3_W'(zsel) * M3_W'(m2_reg);
        end
        if (cmd.sum)
        begin
            if (sel_old_reg)
            begin
                old_cell_reg <= idx[CELL_W-1:0];
                old_ok_reg   <= inrange_reg && (idx < SUM_W'(NUM_CELLS));
            end
            else
            begin
                new_cell_reg <= idx[CELL_W-1:0];
                new_ok_reg   <= inrange_reg && (idx < SUM_W'(NUM_CELLS));
            end
        end
        wc_reg <= wc_next;
        if (cmd.n_load)
        begin
            n_reg <= cnt_q;
        end
        if (cmd.i_clr)
        begin
            i_reg <= '0;
        end
        else if (cmd.i_inc)
        begin
            i_reg <= i_reg + 1'b1;
        end
        if (cmd.emit)
        begin
            result_reg.member_id <= cmd.emit_member ? ent_q : '0;
            result_reg.status    <= cmd.emit_status;
            result_reg.last      <= cmd.emit_last;
        end
    end

    // count memory, cleared by the sweep after reset
    assign cnt_we    = cmd.clr_step ? clr_cells : (cmd.cnt_op != CNT_NONE);
    assign cnt_waddr = cmd.clr_step ? clr_reg[CELL_W-1:0] : wc_reg;
    assign cnt_wdata = cmd.clr_step ? '0 :
                       (cmd.cnt_op == CNT_INC) ? n_reg + 1'b1 : n_reg - 1'b1;

    always_ff @(posedge clk)
    begin
        if (cnt_we)
        begin
            cnt_mem[cnt_waddr] <= cnt_wdata;
        end
        cnt_q <= cnt_mem[wc_reg];
    end

    // home memory: valid bit above the cell index
    assign home_raddr = id_ext[HOME_AW-1:0];
    assign home_we    = cmd.clr_step ? clr_homes : (cmd.home_op != HOME_NONE);
    assign home_waddr = cmd.clr_step ? clr_reg[HOME_AW-1:0] : home_raddr;
    assign home_wdata = (!cmd.clr_step && cmd.home_op == HOME_SET) ? {1'b1, wc_reg} : '0;

    always_ff @(posedge clk)
    begin
        if (home_we)
        begin
            home_mem[home_waddr] <= home_wdata;
        end
        home_q <= home_mem[home_raddr];
    end

    // bucket entries
    assign rd_idx    = cmd.rd_tail ? IDX_W'(n_reg - 1'b1) : i_reg;
    assign wr_idx    = cmd.ent_append ? IDX_W'(n_reg) : i_reg;
    assign ent_raddr = ENT_AW'(wc_reg) * ENT_AW'(BUCKET_DEPTH) + ENT_AW'(rd_idx);
    assign ent_waddr = ENT_AW'(wc_reg) * ENT_AW'(BUCKET_DEPTH) + ENT_AW'(wr_idx);
    assign ent_wdata = cmd.ent_append ? item_reg.entity_id : ent_q;
    assign ent_we    = cmd.ent_append || cmd.ent_swap;

    always_ff @(posedge clk)
    begin
        if (ent_we)
        begin
            ent_mem[ent_waddr] <= ent_wdata;
        end
        ent_q <= ent_mem[ent_raddr];
    end

    assign sts.clr_done   = clr_ext == 32'(CLR_N - 1);
    assign sts.div_done   = !busy_x && !busy_y;
    assign sts.new_ok     = new_ok_reg;
    assign sts.old_ok     = old_ok_reg;
    assign sts.same_cell  = new_cell_reg == old_cell_reg;
    assign sts.cnt_zero   = cnt_q == '0;
    assign sts.cnt_full   = cnt_q >= CNT_W'(BUCKET_DEPTH);
    assign sts.home_valid = home_q[CELL_W];
    assign sts.ent_match  = ent_q == item_reg.entity_id;
    assign sts.i_last     = (CNT_W'(i_reg) + 1'b1) == n_reg;
    assign sts.id_bad     = id_ext >= 32'(NUM_ENTITIES);
    assign sts.qc_bad     = qc_ext >= 32'(NUM_CELLS);
    assign sts.mode       = item_reg.mode;

    assign result = result_reg;
    assign strobe = strobe_reg;

endmodule

[rtl/core/sget_ctrl.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sget_ctrl
// Sequencer for insert, remove, move and query over the datapath.
// ----------------------------------------------------------------------------
module sget_ctrl
    import sget_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    start,
    input  dp_sts_t sts,
    output dp_cmd_t cmd,
    output logic    busy
);

    typedef enum logic [4:0] {
        S_CLEAR,
        S_IDLE,
        S_DISP,
        S_DIV,
        S_MUL1,
        S_MUL2,
        S_SUM,
        S_ROUTE,
        S_Q_CNT,
        S_Q_CHK,
        S_Q_RD,
        S_Q_EMIT,
        S_R_HOME,
        S_A_CNT,
        S_A_CHK,
        S_A_WR,
        S_M_CNT,
        S_M_CHK,
        S_T_CNT,
        S_T_CHK,
        S_T_RD,
        S_T_CMP,
        S_T_LAST,
        S_T_SWAP
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   calc_old_reg;
    logic   calc_old_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_CLEAR;
            calc_old_reg <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            calc_old_reg <= calc_old_next;
        end
    end

    always_comb
    begin
        state_next    = state_reg;
        calc_old_next = calc_old_reg;
        cmd           = '0;
        cmd.wc_src    = WC_HOLD;
        cmd.cnt_op    = CNT_NONE;
        cmd.home_op   = HOME_NONE;
        cmd.emit_last = 1'b1;
        case (state_reg)
            S_CLEAR:
            begin
                cmd.clr_step = 1'b1;
                if (sts.clr_done)
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (start)
                begin
                    cmd.load   = 1'b1;
                    state_next = S_DISP;
                end
            end
            S_DISP:
            begin
                if (sts.mode == MODE_QUERY)
                begin
                    if (sts.qc_bad)
                    begin
                        cmd.emit        = 1'b1;
                        cmd.emit_status = ST_OUT;
                        state_next      = S_IDLE;
                    end
                    else
                    begin
                        cmd.wc_src = WC_QC;
                        state_next = S_Q_CNT;
                    end
                end
                else if (sts.id_bad)
                begin
                    cmd.emit        = 1'b1;
                    cmd.emit_status = ST_NOT_FOUND;
                    state_next      = S_IDLE;
                end
                else if (sts.mode == MODE_REMOVE)
                begin
                    state_next = S_R_HOME;
                end
                else
                begin
                    // move works out the old cell first
                    cmd.div_go    = 1'b1;
                    cmd.div_old   = sts.mode == MODE_MOVE;
                    calc_old_next = sts.mode == MODE_MOVE;
                    state_next    = S_DIV;
                end
            end
            S_DIV:
            begin
                if (sts.div_done)
                begin
                    state_next = S_MUL1;
                end
            end
            S_MUL1:
            begin
                cmd.mul1   = 1'b1;
                state_next = S_MUL2;
            end
            S_MUL2:
            begin
                cmd.mul2   = 1'b1;
                state_next = S_SUM;
            end
            S_SUM:
            begin
                cmd.sum = 1'b1;
                if (calc_old_reg)
                begin
                    cmd.div_go    = 1'b1;
                    calc_old_next = 1'b0;
                    state_next    = S_DIV;
                end
                else
                begin
                    state_next = S_ROUTE;
                end
            end
            S_ROUTE:
            begin
                if (sts.mode == MODE_INSERT)
                begin
                    if (!sts.new_ok)
                    begin
                        cmd.emit        = 1'b1;
                        cmd.emit_status = ST_OUT;
                        state_next      = S_IDLE;
                    end
                    else
                    begin
                        cmd.wc_src = WC_NEW;
                        state_next = S_A_CNT;
                    end
                end
                else if (!sts.old_ok || !sts.new_ok)
                begin
                    cmd.emit        = 1'b1;
                    cmd.emit_status = ST_OUT;
                    state_next      = S_IDLE;
                end
                else if (sts.same_cell)
                begin
                    cmd.emit        = 1'b1;
                    cmd.emit_status = ST_OK;
                    state_next      = S_IDLE;
                end
                else
                begin
                    cmd.wc_src = WC_NEW;
                    state_next = S_M_CNT;
                end
            end
            S_Q_CNT:
            begin
                state_next = S_Q_CHK;
            end
            S_Q_CHK:
            begin
                cmd.n_load = 1'b1;
                cmd.i_clr  = 1'b1;
                if (sts.cnt_zero)
                begin
                    cmd.emit        = 1'b1;
                    cmd.emit_status = ST_EMPTY;
                    state_next      = S_IDLE;
                end
                else
                begin
                    state_next = S_Q_RD;
                end
            end
            S_Q_RD:
            begin
                state_next = S_Q_EMIT;
            end
            S_Q_EMIT:
            begin
                cmd.emit        = 1'b1;
                cmd.emit_status = ST_OK;
                cmd.emit_member = 1'b1;
                cmd.emit_last   = sts.i_last;
                if (sts.i_last)
                begin
                    state_next = S_IDLE;
                end
                else
                begin
                    cmd.i_inc  = 1'b1;
                    state_next = S_Q_RD;
                end
            end
            S_R_HOME:
            begin
                if (!sts.home_valid)
                begin
                    cmd.emit        = 1'b1;
                    cmd.emit_status = ST_NOT_FOUND;
                    state_next      = S_IDLE;
                end
                else
                begin
                    cmd.wc_src  = WC_HOME;
                    cmd.home_op = HOME_CLR;
                    state_next  = S_T_CNT;
                end
            end
            S_A_CNT:
            begin
                state_next = S_A_CHK;
            end
            S_A_CHK:
            begin
                if (sts.cnt_full)
                begin
                    cmd.emit        = 1'b1;
                    cmd.emit_status = ST_FULL;
                    state_next      = S_IDLE;
                end
                else
                begin
                    cmd.n_load = 1'b1;
                    state_next = S_A_WR;
                end
            end
            S_A_WR:
            begin
                cmd.ent_append  = 1'b1;
                cmd.cnt_op      = CNT_INC;
                cmd.home_op     = HOME_SET;
                cmd.emit        = 1'b1;
                cmd.emit_status = ST_OK;
                state_next      = S_IDLE;
            end
            S_M_CNT:
            begin
                state_next = S_M_CHK;
            end
            S_M_CHK:
            begin
                if (sts.cnt_full)
                begin
                    cmd.emit        = 1'b1;
                    cmd.emit_status = ST_FULL;
                    state_next      = S_IDLE;
                end
                else
                begin
                    cmd.wc_src = WC_OLD;
                    state_next = S_T_CNT;
                end
            end
            S_T_CNT:
            begin
                state_next = S_T_CHK;
            end
            S_T_CHK:
            begin
                cmd.n_load = 1'b1;
                cmd.i_clr  = 1'b1;
                if (!sts.cnt_zero)
                begin
                    state_next = S_T_RD;
                end
                else if (sts.mode == MODE_REMOVE)
                begin
                    cmd.emit        = 1'b1;
                    cmd.emit_status = ST_NOT_FOUND;
                    state_next      = S_IDLE;
                end
                else
                begin
                    cmd.wc_src = WC_NEW;
                    state_next = S_A_CNT;
                end
            end
            S_T_RD:
            begin
                state_next = S_T_CMP;
            end
            S_T_CMP:
            begin
                if (sts.ent_match)
                begin
                    state_next = S_T_LAST;
                end
                else if (!sts.i_last)
                begin
                    cmd.i_inc  = 1'b1;
                    state_next = S_T_RD;
                end
                else if (sts.mode == MODE_REMOVE)
                begin
                    cmd.emit        = 1'b1;
                    cmd.emit_status = ST_NOT_FOUND;
                    state_next      = S_IDLE;
                end
                else
                begin
                    // id missing from the old bucket: still file it in the new one
                    cmd.wc_src = WC_NEW;
                    state_next = S_A_CNT;
                end
            end
            S_T_LAST:
            begin
                cmd.rd_tail = 1'b1;
                state_next  = S_T_SWAP;
            end
            S_T_SWAP:
            begin
                // tail entry overwrites the match, bucket shrinks by one
                cmd.ent_swap = 1'b1;
                cmd.cnt_op   = CNT_DEC;
                if (sts.mode == MODE_REMOVE)
                begin
                    cmd.emit        = 1'b1;
                    cmd.emit_status = ST_OK;
                    state_next      = S_IDLE;
                end
                else
                begin
                    cmd.wc_src = WC_NEW;
                    state_next = S_A_CNT;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    assign busy = state_reg != S_IDLE;

endmodule

[rtl/core/spatial_grid_entity_table.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// spatial_grid_entity_table
// Uniform 3D grid that files entity ids into bounded per-cell buckets.
// ----------------------------------------------------------------------------
// After reset the block sweeps its count and home memories with busy high;
// configuration writes are taken during that time. An item is taken when
// start is high and busy is low, and busy stays high until its last result
// has been issued. Results come one per strobe and cannot be held off. The
// run time of insert and move is set by the cell index path, a divider that
// makes one quotient bit per cycle followed by two multiplier stages.
// Remove and move scan the bucket entries, and a query streams its
// members, one memory read per entry.
// ----------------------------------------------------------------------------
module spatial_grid_entity_table
    import sget_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    output logic              busy,
    input  item_t             item,
    output result_t           result,
    output logic              strobe,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [31:0]       pwdata,
    output logic [31:0]       prdata,
    output logic              pready
);

    cfg_t    cfg_reg;
    dp_cmd_t cmd;
    dp_sts_t sts;
    logic    cfg_we;

    assign pready = 1'b1;
    assign cfg_we = psel && penable && pwrite;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.cell_size <= CS_W'(1);
            cfg_reg.cells_x   <= DIM_W'(64);
            cfg_reg.cells_y   <= DIM_W'(64);
        end
        else if (cfg_we)
        begin
            case (paddr[3:2])
                REG_CELL_SIZE: cfg_reg.cell_size <= pwdata[CS_W-1:0];
                REG_CELLS_X:   cfg_reg.cells_x   <= pwdata[DIM_W-1:0];
                REG_CELLS_Y:   cfg_reg.cells_y   <= pwdata[DIM_W-1:0];
                default:       ;
            endcase
        end
    end

    always_comb
    begin
        case (paddr[3:2])
            REG_CELL_SIZE: prdata = 32'(cfg_reg.cell_size);
            REG_CELLS_X:   prdata = 32'(cfg_reg.cells_x);
            REG_CELLS_Y:   prdata = 32'(cfg_reg.cells_y);
            default:       prdata = '0;
        endcase
    end

    sget_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .sts   (sts),
        .cmd   (cmd),
        .busy  (busy)
    );

    sget_dp u_dp (
        .clk    (clk),
        .rst_n  (rst_n),
        .cfg    (cfg_reg),
        .item   (item),
        .cmd    (cmd),
        .sts    (sts),
        .result (result),
        .strobe (strobe)
    );

    // an accepted beat always keeps the block busy for the next cycle
    assert property (@(posedge clk) disable iff (!rst_n)
        start && !busy |=> busy)
        else $error("busy not raised after accepted item");

    // results never come in consecutive cycles
    assert property (@(posedge clk) disable iff (!rst_n)
        strobe |=> !strobe)
        else $error("back to back result beats");

    // any status other than ok closes its item
    assert property (@(posedge clk) disable iff (!rst_n)
        strobe && result.status != ST_OK |-> result.last)
        else $error("error status without last");

    // only a query member carries an id
    assert property (@(posedge clk) disable iff (!rst_n)
        strobe && result.status != ST_OK |-> result.member_id == '0)
        else $error("nonzero member id on error result");

endmodule
